FILE: sv/npz_pkg.sv
package npz_pkg;

   localparam int MOM_W       = 24;
   localparam int FRAC_BITS   = 8;
   localparam int E_W         = MOM_W - 1;
   localparam int DMAG_W      = 47;
   localparam int NUM_W       = 74;
   localparam int RAD_W       = 100;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int SQ_REM_W    = ROOT_W + 2;
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int DIV_STEPS   = MOM_W;
   localparam int DIV_W       = 76;
   localparam int BACK_STAGES = SQRT_STEPS + DIV_STEPS + 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] W_MASS_RESET = 16'(((8038 << FRAC_BITS) + 50) / 100);

   localparam logic [0:0] REG_W_MASS = 1'd0;
   localparam logic [0:0] REG_MODE   = 1'd1;

   localparam logic [1:0] MODE_SMALLER = 2'd0;
   localparam logic [1:0] MODE_PLUS    = 2'd1;
   localparam logic [1:0] MODE_MINUS   = 2'd2;
   localparam logic [1:0] MODE_ZERO    = 2'd3;

   localparam logic [1:0] STATUS_REAL    = 2'd0;
   localparam logic [1:0] STATUS_COMPLEX = 2'd1;
   localparam logic [1:0] STATUS_DEGEN   = 2'd2;

   localparam logic [MOM_W-1:0] PZ_MAX = {1'b0, {(MOM_W - 1){1'b1}}};
   localparam logic [MOM_W-1:0] PZ_MIN = {1'b1, {(MOM_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_REAL,
      KIND_COMPLEX,
      KIND_ZERO,
      KIND_DEGEN
   } kind_type;

   typedef struct packed {
      logic signed [MOM_W-1:0] lepton_px;
      logic signed [MOM_W-1:0] lepton_py;
      logic signed [MOM_W-1:0] lepton_pz;
      logic [E_W-1:0]          lepton_energy;
      logic signed [MOM_W-1:0] met_px;
      logic signed [MOM_W-1:0] met_py;
   } req_type;

   typedef struct packed {
      logic signed [MOM_W-1:0] neutrino_pz;
      logic [1:0]              root_status;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [15:0] w_mass;
      logic [1:0]  mode;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic              minus;
      logic              dsgn;
      logic [DMAG_W-1:0] dmag;
      logic [E_W-1:0]    e;
      logic [NUM_W-1:0]  num;
   } item_type;

   typedef struct packed {
      item_type         item;
      logic [RAD_W-1:0] rad;
   } mid_type;

endpackage

FILE: sv/npz_queue.sv
module npz_queue import npz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mid_type push_data,
   input  logic    pop,
   output mid_type pop_data,
   output logic    full,
   output logic    empty
);

   mid_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

FILE: sv/npz_front.sv
module npz_front import npz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    push,
   output mid_type push_data,
   input  logic    q_full,
   input  logic    q_pop
);

   logic        en;
   logic [5:0]  v_ff;

   logic [47:0] s1_pxx_in, s1_pyy_in, s1_mx2_in, s1_my2_in, s1_pz2_in;
   logic [45:0] s1_e2_in;
   logic [31:0] s1_w2_in;
   logic [47:0] s1_pxx_ff, s1_pyy_ff, s1_mx2_ff, s1_my2_ff, s1_pz2_ff;
   logic [45:0] s1_e2_ff;
   logic [31:0] s1_w2_ff;
   logic [23:0] s1_pz_ff;
   logic [22:0] s1_e_ff;

   logic [48:0] s2_sum_in;
   logic [49:0] s2_m_ff;
   logic [47:0] s2_d_ff, s2_t_ff;
   logic [23:0] s2_pz_ff;
   logic [22:0] s2_e_ff;

   logic [48:0] s3_mmag_ff;
   logic        s3_msgn_ff;
   logic [46:0] s3_dmag_ff;
   logic        s3_dsgn_ff, s3_dzero_ff;
   logic [47:0] s3_t_ff;
   logic [23:0] s3_pzmag_ff;
   logic        s3_pzsgn_ff;
   logic [22:0] s3_e_ff;

   logic [24:0] ml, dl, tl;
   logic [23:0] mh;
   logic [21:0] dh;
   logic [22:0] th;
   logic [49:0] s4_mm_ll_ff, s4_dt_ll_ff;
   logic [48:0] s4_mm_lh_ff, s4_n_l_ff;
   logic [47:0] s4_mm_hh_ff, s4_n_h_ff, s4_dt_lh_ff;
   logic [46:0] s4_dt_hl_ff;
   logic [44:0] s4_dt_hh_ff;
   logic        s4_nsgn_ff, s4_dsgn_ff, s4_dzero_ff;
   logic [46:0] s4_dmag_ff;
   logic [22:0] s4_e_ff;

   logic [97:0] s5_msq_ff;
   logic [94:0] s5_dt_ff;
   logic [72:0] s5_nmag_ff;
   logic        s5_nsgn_ff, s5_dsgn_ff, s5_dzero_ff;
   logic [46:0] s5_dmag_ff;
   logic [22:0] s5_e_ff;

   logic [99:0] s6_q_ff;
   logic [73:0] s6_num_ff;
   logic        s6_dsgn_ff, s6_dzero_ff;
   logic [46:0] s6_dmag_ff;
   logic [22:0] s6_e_ff;

   logic        qpos;
   logic        minus;
   kind_type    kind;

   assign en        = !v_ff[5] || !q_full || q_pop;
   assign req_ready = en;
   assign push      = v_ff[5] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], req_valid};
      end
   end

   always_comb begin
      s1_pxx_in = $signed(req_data.met_px) * $signed(req_data.lepton_px);
      s1_pyy_in = $signed(req_data.met_py) * $signed(req_data.lepton_py);
      s1_mx2_in = $signed(req_data.met_px) * $signed(req_data.met_px);
      s1_my2_in = $signed(req_data.met_py) * $signed(req_data.met_py);
      s1_pz2_in = $signed(req_data.lepton_pz) * $signed(req_data.lepton_pz);
      s1_e2_in  = req_data.lepton_energy * req_data.lepton_energy;
      s1_w2_in  = cfg.w_mass * cfg.w_mass;
   end

   assign s2_sum_in = {s1_pxx_ff[47], s1_pxx_ff} + {s1_pyy_ff[47], s1_pyy_ff};

   assign ml = s3_mmag_ff[24:0];
   assign mh = s3_mmag_ff[48:25];
   assign dl = s3_dmag_ff[24:0];
   assign dh = s3_dmag_ff[46:25];
   assign tl = s3_t_ff[24:0];
   assign th = s3_t_ff[47:25];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pxx_ff <= s1_pxx_in;
         s1_pyy_ff <= s1_pyy_in;
         s1_mx2_ff <= s1_mx2_in;
         s1_my2_ff <= s1_my2_in;
         s1_pz2_ff <= s1_pz2_in;
         s1_e2_ff  <= s1_e2_in;
         s1_w2_ff  <= s1_w2_in;
         s1_pz_ff  <= req_data.lepton_pz;
         s1_e_ff   <= req_data.lepton_energy;

         s2_m_ff  <= {18'd0, s1_w2_ff} + {s2_sum_in, 1'b0};
         s2_d_ff  <= {2'd0, s1_e2_ff} - s1_pz2_ff;
         s2_t_ff  <= s1_mx2_ff + s1_my2_ff;
         s2_pz_ff <= s1_pz_ff;
         s2_e_ff  <= s1_e_ff;

         s3_mmag_ff  <= s2_m_ff[49] ? 49'(50'd0 - s2_m_ff) : s2_m_ff[48:0];
         s3_msgn_ff  <= s2_m_ff[49];
         s3_dmag_ff  <= s2_d_ff[47] ? 47'(48'd0 - s2_d_ff) : s2_d_ff[46:0];
         s3_dsgn_ff  <= s2_d_ff[47];
         s3_dzero_ff <= (s2_d_ff == '0);
         s3_t_ff     <= s2_t_ff;
         s3_pzmag_ff <= s2_pz_ff[23] ? 24'd0 - s2_pz_ff : s2_pz_ff;
         s3_pzsgn_ff <= s2_pz_ff[23];
         s3_e_ff     <= s2_e_ff;

         s4_mm_ll_ff <= ml * ml;
         s4_mm_lh_ff <= ml * mh;
         s4_mm_hh_ff <= mh * mh;
         s4_n_l_ff   <= ml * s3_pzmag_ff;
         s4_n_h_ff   <= mh * s3_pzmag_ff;
         s4_dt_ll_ff <= dl * tl;
         s4_dt_lh_ff <= dl * th;
         s4_dt_hl_ff <= dh * tl;
         s4_dt_hh_ff <= dh * th;
         s4_nsgn_ff  <= s3_msgn_ff ^ s3_pzsgn_ff;
         s4_dsgn_ff  <= s3_dsgn_ff;
         s4_dzero_ff <= s3_dzero_ff;
         s4_dmag_ff  <= s3_dmag_ff;
         s4_e_ff     <= s3_e_ff;

         s5_msq_ff   <= {s4_mm_hh_ff, 50'd0} + 98'({s4_mm_lh_ff, 26'd0}) + 98'(s4_mm_ll_ff);
         s5_dt_ff    <= {s4_dt_hh_ff, 50'd0}
                        + 95'({49'(49'(s4_dt_lh_ff) + 49'(s4_dt_hl_ff)), 25'd0})
                        + 95'(s4_dt_ll_ff);
         s5_nmag_ff  <= {s4_n_h_ff, 25'd0} + 73'(s4_n_l_ff);
         s5_nsgn_ff  <= s4_nsgn_ff;
         s5_dsgn_ff  <= s4_dsgn_ff;
         s5_dzero_ff <= s4_dzero_ff;
         s5_dmag_ff  <= s4_dmag_ff;
         s5_e_ff     <= s4_e_ff;

         s6_q_ff     <= s5_dsgn_ff ? 100'(s5_msq_ff) + 100'({s5_dt_ff, 2'b00})
                                   : 100'(s5_msq_ff) - 100'({s5_dt_ff, 2'b00});
         s6_num_ff   <= s5_nsgn_ff ? 74'd0 - 74'(s5_nmag_ff) : 74'(s5_nmag_ff);
         s6_dsgn_ff  <= s5_dsgn_ff;
         s6_dzero_ff <= s5_dzero_ff;
         s6_dmag_ff  <= s5_dmag_ff;
         s6_e_ff     <= s5_e_ff;
      end
   end

   always_comb begin
      qpos = !s6_q_ff[99] && (s6_q_ff != '0);
      if (s6_dzero_ff) begin
         kind = KIND_DEGEN;
      end else if ((s6_e_ff == '0) || !qpos) begin
         kind = KIND_COMPLEX;
      end else if (cfg.mode == MODE_ZERO) begin
         kind = KIND_ZERO;
      end else begin
         kind = KIND_REAL;
      end
      case (cfg.mode)
         MODE_PLUS: begin
            minus = 1'b0;
         end
         MODE_MINUS: begin
            minus = 1'b1;
         end
         MODE_SMALLER: begin
            minus = (s6_num_ff != '0) && (s6_num_ff[73] == s6_dsgn_ff);
         end
         default: begin
            minus = 1'b0;
         end
      endcase
      push_data.item.kind  = kind;
      push_data.item.minus = minus;
      push_data.item.dsgn  = s6_dsgn_ff;
      push_data.item.dmag  = s6_dmag_ff;
      push_data.item.e     = s6_e_ff;
      push_data.item.num   = s6_num_ff;
      push_data.rad        = s6_q_ff;
   end

endmodule

FILE: sv/npz_back.sv
module npz_back import npz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  mid_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      item_type            item;
      logic [RAD_W-1:0]    rad;
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
   } sq_type;

   typedef struct packed {
      item_type         item;
      logic [DIV_W-1:0] rem;
      logic [MOM_W-1:0] quo;
      logic             over;
      logic             tneg;
   } dv_type;

   logic                   en;
   logic [BACK_STAGES-1:0] back_v_ff;
   sq_type                 sq_ff [SQRT_STEPS + 1];
   dv_type                 dv_ff [DIV_STEPS + 1];

   item_type    ep_item_ff, er_item_ff, tm_item_ff, t1_item_ff, at_item_ff, n_item_ff;
   logic [47:0] ep_lo_ff, ep_hi_ff;
   logic [72:0] er_ff;
   logic [75:0] tm_ff, t1_ff, n_ff;
   logic [74:0] at_ff;
   logic        at_tneg_ff, n_tneg_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_in;
   logic             neg, sat;
   logic [MOM_W-1:0] lim, val;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign q_pop     = en && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         back_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         back_v_ff    <= {back_v_ff[BACK_STAGES-2:0], q_pop};
         rsp_valid_ff <= back_v_ff[BACK_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0].item <= q_data.item;
         sq_ff[0].rad  <= q_data.rad;
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic [SQ_REM_W+1:0] cur;
      logic [SQ_REM_W+1:0] trial;
      sq_type              step_in;
      always_comb begin
         cur          = {sq_ff[i].rem, sq_ff[i].rad[RAD_W-1 -: 2]};
         trial        = {2'b00, sq_ff[i].root, 2'b01};
         step_in      = sq_ff[i];
         step_in.rad  = {sq_ff[i].rad[RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            step_in.rem  = SQ_REM_W'(cur - trial);
            step_in.root = {sq_ff[i].root[ROOT_W-2:0], 1'b1};
         end else begin
            step_in.rem  = cur[SQ_REM_W-1:0];
            step_in.root = {sq_ff[i].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i+1] <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ep_item_ff <= sq_ff[SQRT_STEPS].item;
         ep_lo_ff   <= sq_ff[SQRT_STEPS].item.e * sq_ff[SQRT_STEPS].root[24:0];
         ep_hi_ff   <= sq_ff[SQRT_STEPS].item.e * sq_ff[SQRT_STEPS].root[49:25];

         er_item_ff <= ep_item_ff;
         er_ff      <= {ep_hi_ff, 25'd0} + 73'(ep_lo_ff);

         tm_item_ff <= er_item_ff;
         if (er_item_ff.kind == KIND_REAL) begin
            tm_ff <= (er_item_ff.dsgn ^ er_item_ff.minus) ? 76'd0 - 76'(er_ff) : 76'(er_ff);
         end else begin
            tm_ff <= '0;
         end

         t1_item_ff <= tm_item_ff;
         t1_ff      <= {{2{tm_item_ff.num[73]}}, tm_item_ff.num} + tm_ff;

         at_item_ff <= t1_item_ff;
         at_ff      <= t1_ff[75] ? 75'(76'd0 - t1_ff) : t1_ff[74:0];
         at_tneg_ff <= t1_ff[75];

         n_item_ff  <= at_item_ff;
         n_ff       <= 76'(at_ff) + 76'(at_item_ff.dmag);
         n_tneg_ff  <= at_tneg_ff;

         dv_ff[0].item <= n_item_ff;
         dv_ff[0].rem  <= n_ff;
         dv_ff[0].quo  <= '0;
         dv_ff[0].over <= (n_ff >= 76'({n_item_ff.dmag, 1'b0, 24'd0}));
         dv_ff[0].tneg <= n_tneg_ff;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [DIV_W-1:0] sub;
      dv_type           step_in;
      always_comb begin
         sub     = DIV_W'({dv_ff[j].item.dmag, 1'b0}) << (DIV_STEPS - 1 - j);
         step_in = dv_ff[j];
         if (dv_ff[j].rem >= sub) begin
            step_in.rem = dv_ff[j].rem - sub;
            step_in.quo = {dv_ff[j].quo[MOM_W-2:0], 1'b1};
         end else begin
            step_in.quo = {dv_ff[j].quo[MOM_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j+1] <= step_in;
         end
      end
   end

   always_comb begin
      neg = (dv_ff[DIV_STEPS].tneg ^ dv_ff[DIV_STEPS].item.dsgn)
            && (dv_ff[DIV_STEPS].over || (dv_ff[DIV_STEPS].quo != '0));
      lim = neg ? PZ_MIN : PZ_MAX;
      sat = dv_ff[DIV_STEPS].over || (dv_ff[DIV_STEPS].quo > lim);
      if (sat) begin
         val = lim;
      end else if (neg) begin
         val = MOM_W'(0) - dv_ff[DIV_STEPS].quo;
      end else begin
         val = dv_ff[DIV_STEPS].quo;
      end
      case (dv_ff[DIV_STEPS].item.kind)
         KIND_DEGEN: begin
            rsp_in.neutrino_pz = '0;
            rsp_in.root_status = STATUS_DEGEN;
            rsp_in.saturated   = 1'b0;
         end
         KIND_ZERO: begin
            rsp_in.neutrino_pz = '0;
            rsp_in.root_status = STATUS_REAL;
            rsp_in.saturated   = 1'b0;
         end
         KIND_COMPLEX: begin
            rsp_in.neutrino_pz = val;
            rsp_in.root_status = STATUS_COMPLEX;
            rsp_in.saturated   = sat;
         end
         default: begin
            rsp_in.neutrino_pz = val;
            rsp_in.root_status = STATUS_REAL;
            rsp_in.saturated   = sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

FILE: sv/neutrino_pz_w_mass_constraint_core.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_data  (req_type)
// rsp       out        rsp_valid/rsp_ready   rsp_data  (rsp_type)
// csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle sustained while rsp_ready stays high; each item passes
// through the 6 front stages, the queue, and the back pipeline with its 50
// square-root steps and 24 divide steps.
// Reset clears all valid bits and loads w_mass 20577, solution_mode 0.
// rsp_ready low freezes the back pipeline; the front keeps taking items
// until the four-entry queue is full and its last stage holds an item.
module neutrino_pz_w_mass_constraint_core import npz_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        w_mass_ff_en;
   logic [15:0] w_mass_ff;
   logic [1:0]  mode_ff;
   logic [0:0]  reg_idx;
   cfg_type     cfg;
   logic        push, pop, q_full, q_empty;
   mid_type     push_data, pop_data;

   assign pready       = 1'b1;
   assign reg_idx      = paddr[2];
   assign w_mass_ff_en = psel && penable && pwrite && pready;
   assign cfg.w_mass   = w_mass_ff;
   assign cfg.mode     = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_mass_ff <= W_MASS_RESET;
         mode_ff   <= MODE_SMALLER;
      end else if (w_mass_ff_en) begin
         case (reg_idx)
            REG_W_MASS: begin
               w_mass_ff <= pwdata[15:0];
            end
            REG_MODE: begin
               mode_ff <= pwdata[1:0];
            end
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_W_MASS: begin
            prdata = {16'd0, w_mass_ff};
         end
         REG_MODE: begin
            prdata = {30'd0, mode_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   npz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full),
      .q_pop     (pop)
   );

   npz_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   npz_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/tb_neutrino_pz_w_mass_constraint_core.sv
module tb_neutrino_pz_w_mass_constraint_core;
   import npz_pkg::*;

   typedef logic signed [199:0] wide_type;
   typedef logic [199:0] uwide_type;

   class npz_scoreboard;
      rsp_type     pending[$];
      logic [15:0] w_mass;
      logic [1:0]  mode;
      int          errors;

      function new();
         w_mass = W_MASS_RESET;
         mode   = MODE_SMALLER;
         errors = 0;
      endfunction

      function wide_type sx(logic [MOM_W-1:0] v);
         return {{(200 - MOM_W){v[MOM_W-1]}}, v};
      endfunction

      function logic [127:0] isqrt(logic [127:0] a);
         logic [129:0] rem;
         logic [129:0] trial;
         logic [127:0] root;
         rem  = 0;
         root = 0;
         for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | a[2*i +: 2];
            trial = {root, 2'b01};
            root  = root << 1;
            if (rem >= trial) begin
               rem     = rem - trial;
               root[0] = 1'b1;
            end
         end
         return root;
      endfunction

      function rsp_type round_sat(wide_type num, wide_type den, logic [1:0] status);
         uwide_type an;
         uwide_type ad;
         uwide_type q;
         uwide_type lim;
         logic      neg;
         rsp_type   r;
         an  = num < 0 ? -num : num;
         ad  = den < 0 ? -den : den;
         q   = (an + ad) / (ad << 1);
         neg = ((num < 0) != (den < 0)) && (q != 0);
         lim = neg ? (uwide_type'(1) << (MOM_W - 1)) : ((uwide_type'(1) << (MOM_W - 1)) - 1);
         r.root_status = status;
         if (q > lim) begin
            r.saturated   = 1'b1;
            r.neutrino_pz = neg ? PZ_MIN : PZ_MAX;
         end else begin
            r.saturated   = 1'b0;
            r.neutrino_pz = neg ? -q[MOM_W-1:0] : q[MOM_W-1:0];
         end
         return r;
      endfunction

      function rsp_type solve_pz(req_type x);
         wide_type lx, ly, pz, e, mx, my, wm, m, dn, tt, qd, num, er, t;
         logic     take_minus;
         rsp_type  r;
         lx = sx(x.lepton_px);
         ly = sx(x.lepton_py);
         pz = sx(x.lepton_pz);
         mx = sx(x.met_px);
         my = sx(x.met_py);
         e  = 0;
         e[E_W-1:0] = x.lepton_energy;
         wm = 0;
         wm[15:0] = w_mass;
         m  = wm * wm + 2 * (mx * lx + my * ly);
         dn = e * e - pz * pz;
         if (dn == 0) begin
            r.neutrino_pz = '0;
            r.root_status = STATUS_DEGEN;
            r.saturated   = 1'b0;
            return r;
         end
         tt  = mx * mx + my * my;
         qd  = m * m - 4 * dn * tt;
         num = m * pz;
         if (e == 0 || qd <= 0)
            return round_sat(num, dn, STATUS_COMPLEX);
         if (mode == MODE_ZERO) begin
            r.neutrino_pz = '0;
            r.root_status = STATUS_REAL;
            r.saturated   = 1'b0;
            return r;
         end
         er = 0;
         er[127:0] = isqrt(qd[127:0]);
         er = e * er;
         if (dn < 0)
            er = -er;
         if (mode == MODE_PLUS)
            take_minus = 1'b0;
         else if (mode == MODE_MINUS)
            take_minus = 1'b1;
         else
            take_minus = (num != 0) && ((num < 0) == (dn < 0));
         t = take_minus ? num - er : num + er;
         return round_sat(t, dn, STATUS_REAL);
      endfunction

      function void note_item(req_type x);
         pending.insert(pending.size(), solve_pz(x));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected item %h", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.neutrino_pz !== want.neutrino_pz) begin
            errors++;
            $display("%0t: neutrino_pz expected %0d actual %0d", $time,
                     want.neutrino_pz, got.neutrino_pz);
         end
         if (got.root_status !== want.root_status) begin
            errors++;
            $display("%0t: root_status expected %0d actual %0d", $time,
                     want.root_status, got.root_status);
         end
         if (got.saturated !== want.saturated) begin
            errors++;
            $display("%0t: saturated expected %0d actual %0d", $time,
                     want.saturated, got.saturated);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   npz_scoreboard sb;
   int            cycles = 0;
   int            accepted = 0;
   logic          hold_done = 1'b0;

   neutrino_pz_w_mass_constraint_core dut (.*);

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
         accepted <= accepted + 1;
      end
   end

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && accepted >= 100) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
         repeat (n) @(negedge clock);
      end
   end

   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == 3'(4 * REG_W_MASS))
         sb.w_mass = data[15:0];
      else
         sb.mode = data[1:0];
   endtask

   task automatic send_item(req_type x, logic gap);
      int n;
      req_valid <= 1'b1;
      req_data  <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(x);
      @(negedge clock);
      if (gap) begin
         req_valid <= 1'b0;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic logic [MOM_W-1:0] rand_mom();
      int k;
      k = $urandom_range(4, MOM_W - 1);
      if ($urandom_range(0, 4) == 0)
         return MOM_W'($urandom);
      return MOM_W'($signed($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1)));
   endfunction

   function automatic req_type rand_item();
      req_type x;
      int      kind;
      logic [MOM_W:0] mag;
      kind = $urandom_range(0, 19);
      x.lepton_px = rand_mom();
      x.lepton_py = rand_mom();
      x.lepton_pz = rand_mom();
      x.met_px    = rand_mom();
      x.met_py    = rand_mom();
      mag = (x.lepton_pz[MOM_W-1] ? -x.lepton_pz : x.lepton_pz);
      if (kind < 3) begin
         x.lepton_energy = E_W'($urandom);
      end else if (kind < 5) begin
         x.lepton_pz[MOM_W-1] = 1'b0;
         x.lepton_energy = x.lepton_pz[E_W-1:0];
         if ($urandom_range(0, 1))
            x.lepton_pz = -x.lepton_pz;
      end else if (kind == 5) begin
         x.lepton_energy = '0;
      end else begin
         mag = mag + 25'($urandom_range(0, 4000));
         x.lepton_energy = (mag > 25'h7fffff) ? '1 : mag[E_W-1:0];
      end
      return x;
   endfunction

   initial begin
      req_type x;
      logic [15:0] masses[5];
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item('{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff,
                  24'sh7fffff, 24'sh7fffff}, 1'b1);
      send_item('{24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff,
                  24'sh800000, 24'sh800000}, 1'b1);
      send_item('0, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh001000, 23'h0, 24'sh10, 24'sh0}, 1'b0);
      send_item('{24'sh0, 24'sh0, 24'sh001000, 23'h001000, 24'sh10, 24'sh0}, 1'b0);
      send_item('{24'sh0, 24'sh0, 24'sh800000, 23'h7fffff, 24'sh0, 24'sh0}, 1'b1);
      send_item('{24'sh2000, 24'sh1000, 24'sh3000, 23'h4000, 24'sh1800, 24'sh0800}, 1'b1);
      send_item('{24'sh2000, 24'sh1000, -24'sh3000, 23'h4000, -24'sh1800, 24'sh0800}, 1'b0);
      send_item('{24'sh1, 24'sh1, 24'sh7fff00, 23'h7fffff, 24'sh7fffff, 24'sh800000}, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh0, 23'h1, 24'sh0, 24'sh0}, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh1, 23'h2, 24'sh7fffff, 24'sh7fffff}, 1'b1);
      send_item('{24'sh3000, 24'sh0, 24'sh5000, 23'h1000, 24'sh100, 24'sh100}, 1'b1);
      drain();
      write_reg(3'(4 * REG_MODE), 32'(MODE_PLUS));
      send_item('{24'sh2000, 24'sh1000, 24'sh3000, 23'h4000, 24'sh1800, 24'sh0800}, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh1, 23'h2, 24'sh7fffff, 24'sh7fffff}, 1'b1);
      drain();
      write_reg(3'(4 * REG_MODE), 32'(MODE_MINUS));
      send_item('{24'sh2000, 24'sh1000, 24'sh3000, 23'h4000, 24'sh1800, 24'sh0800}, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh1, 23'h2, 24'sh7fffff, 24'sh7fffff}, 1'b1);
      drain();
      write_reg(3'(4 * REG_MODE), 32'(MODE_ZERO));
      send_item('{24'sh2000, 24'sh1000, 24'sh3000, 23'h4000, 24'sh1800, 24'sh0800}, 1'b1);
      send_item('{24'sh0, 24'sh0, 24'sh001000, 23'h0, 24'sh10, 24'sh0}, 1'b1);
      drain();

      masses = '{W_MASS_RESET, 16'h0, 16'hffff, 16'h1, 16'h0};
      for (int p = 0; p < 5; p++) begin
         if (p == 4)
            masses[p] = 16'($urandom);
         write_reg(3'(4 * REG_W_MASS), 32'(masses[p]));
         write_reg(3'(4 * REG_MODE), (p == 4) ? 32'($urandom_range(0, 3)) : 32'(p));
         for (int i = 0; i < 186; i++) begin
            x = rand_item();
            send_item(x, (i % 60 < 20) ? 1'b0 : ($urandom_range(0, 2) == 0));
         end
         req_valid <= 1'b0;
         drain();
      end

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: sim.f
sv/npz_pkg.sv
sv/npz_queue.sv
sv/npz_front.sv
sv/npz_back.sv
sv/neutrino_pz_w_mass_constraint_core.sv
bench/tb_neutrino_pz_w_mass_constraint_core.sv
